[rtl/afg_pkg.sv]
// shared types and constants for the audio fifo with read gain
package afg_pkg;

  localparam int SampleW   = 24;
  localparam int LenW      = 12;
  localparam int GainW     = 16;
  localparam int FracBits  = 14;
  localparam int ProdW     = SampleW + GainW + 1;

  localparam logic [GainW-1:0] GainReset = 16'd16384;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } afg_state_e;

  typedef struct packed {
    logic                      mode;
    logic signed [SampleW-1:0] sample;
    logic                      burst_start;
    logic [LenW-1:0]           request_length;
  } afg_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic                      out_valid;
    logic                      last;
    logic                      push_ok;
    logic [LenW-1:0]           free_space;
  } afg_out_t;

  // tag that travels beside a sample read from the store
  typedef struct packed {
    logic vld;
    logic last;
  } afg_tag_t;

endpackage

[rtl/afg_ram.sv]
// generic single write port, single read port ram with registered read
module afg_ram #(
  parameter int Width = 24,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/afg_gain.sv]
// gain multiply stage with rounding and 24-bit saturation
module afg_gain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  afg_pkg::afg_tag_t                 tag_i,
  input  logic signed [afg_pkg::SampleW-1:0] sample_i,
  input  logic [afg_pkg::GainW-1:0]         gain_i,
  output afg_pkg::afg_tag_t                 tag_o,
  output logic signed [afg_pkg::SampleW-1:0] sample_o
);
  import afg_pkg::*;

  localparam logic signed [ProdW-1:0] RoundBias = ProdW'(1) <<< (FracBits - 1);
  localparam logic signed [ProdW-1:0] SatMax    = ProdW'(8388607);
  localparam logic signed [ProdW-1:0] SatMin    = -ProdW'(8388608);

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [ProdW-1:0] rounded;
  logic signed [ProdW-1:0] scaled;
  afg_tag_t                tag_q;

  assign prod_d = sample_i * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  // round half up, then clamp
  always_comb begin
    rounded = prod_q + RoundBias;
    scaled  = rounded >>> FracBits;
    if (scaled > SatMax) begin
      sample_o = SampleW'(SatMax);
    end else if (scaled < SatMin) begin
      sample_o = SampleW'(SatMin);
    end else begin
      sample_o = scaled[SampleW-1:0];
    end
  end

  assign tag_o = tag_q;

endmodule

[rtl/audio_fifo_with_read_gain_top.sv]
// top level of the audio sample fifo with gain applied on read
//
// Items enter through in_i with start; a transfer happens at a clock edge with
// start high and busy low. mode 0 pushes one sample: the first sample of a
// burst carries its length and the burst is kept only if it fits the free
// space, otherwise the whole burst is dropped. mode 1 asks for up to
// request_length samples, capped at MAX_POP and at what is stored.
// Results leave on res_o, marked by result_valid_o for exactly one cycle; the
// receiver cannot hold them off.
// A push gives one result in the cycle after its transfer, and busy stays low,
// so a push can be taken every cycle. A pop of n > 0 samples reads the store
// one entry per cycle through its single read port; the first result passes
// the state, store read, gain product and result registers, the rest follow
// one per cycle, and busy stays high until the last has left the gain stage.
// A pop that reads nothing gives one result in the next cycle. The user must
// write the gain register through gain_we_i and gain_wdata_i only while idle;
// the block does not enforce it. Reset empties the fifo (both pointers to
// zero), ends any burst and sets the gain to unity; the store is not cleared.
module audio_fifo_with_read_gain_top #(
  parameter int CAPACITY = 4096,
  parameter int MAX_POP  = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  afg_pkg::afg_in_t              in_i,
  output logic                          result_valid_o,
  output afg_pkg::afg_out_t             res_o,
  input  logic                          gain_we_i,
  input  logic [afg_pkg::GainW-1:0]     gain_wdata_i
);
  import afg_pkg::*;

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = (PW > LenW) ? PW : LenW;
  localparam int CNTW = (MAX_POP > 1) ? $clog2(MAX_POP + 1) : 1;

  afg_state_e            state_q, state_d;
  logic [PW-1:0]         wp_q, wp_d, rp_q, rp_d;
  logic [LenW-1:0]       rem_q, rem_d;
  logic                  acc_q, acc_d;
  logic [GainW-1:0]      gain_q;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic [LenW-1:0]       fs_q, fs_d;
  afg_tag_t              rd_tag_q, rd_tag_d;
  afg_tag_t              mul_tag;
  logic signed [SampleW-1:0] mul_sample;
  logic [SampleW-1:0]    ram_rdata;
  afg_out_t              res_q, res_d;
  logic                  res_vld_q, res_vld_d;

  logic                  xfer;
  logic                  mem_we;
  logic [PW-1:0]         used_p;
  logic [CW-1:0]         used_w, free_w, len_w, n_w;
  logic [CW:0]           fs_pop;
  logic                  burst_ok;

  assign xfer = start && !busy;

  // stored count, wrapping the pointer difference around the ring
  always_comb begin
    used_p = wp_q - rp_q;
    if (wp_q < rp_q) begin
      used_p = used_p + PW'(CAPACITY);
    end
  end

  assign used_w   = CW'(used_p);
  assign free_w   = CW'(CAPACITY - 1) - used_w;
  assign len_w    = CW'(in_i.request_length);
  assign burst_ok = (len_w != '0) && ({1'b0, len_w} < (CW + 1)'(CAPACITY))
                    && (len_w <= free_w);

  always_comb begin
    n_w = len_w;
    if (n_w > CW'(MAX_POP)) begin
      n_w = CW'(MAX_POP);
    end
    if (n_w > used_w) begin
      n_w = used_w;
    end
  end

  assign fs_pop = {1'b0, free_w} + {1'b0, n_w};

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    fs_d      = fs_q;
    rd_tag_d  = '0;
    mem_we    = 1'b0;
    res_vld_d = 1'b0;
    res_d     = res_q;

    case (state_q)
      ST_IDLE: begin
        if (xfer && !in_i.mode) begin
          if (in_i.burst_start) begin
            acc_d = burst_ok;
            if (len_w != '0) begin
              mem_we = burst_ok;
              rem_d  = in_i.request_length - LenW'(1);
            end else begin
              rem_d = '0;
            end
          end else if (rem_q != '0) begin
            mem_we = acc_q;
            rem_d  = rem_q - LenW'(1);
          end
          if (mem_we) begin
            wp_d = (wp_q == PW'(CAPACITY - 1)) ? '0 : wp_q + PW'(1);
          end
          res_vld_d        = 1'b1;
          res_d.out_sample = '0;
          res_d.out_valid  = 1'b0;
          res_d.last       = 1'b1;
          res_d.push_ok    = mem_we;
          res_d.free_space = LenW'(free_w - CW'(mem_we));
        end else if (xfer) begin
          if (n_w == '0) begin
            res_vld_d        = 1'b1;
            res_d.out_sample = '0;
            res_d.out_valid  = 1'b0;
            res_d.last       = 1'b1;
            res_d.push_ok    = 1'b0;
            res_d.free_space = free_w[LenW-1:0];
          end else begin
            state_d = ST_READ;
            cnt_d   = CNTW'(n_w);
            fs_d    = fs_pop[LenW-1:0];
          end
        end
      end
      ST_READ: begin
        rd_tag_d.vld  = 1'b1;
        rd_tag_d.last = (cnt_q == CNTW'(1));
        rp_d  = (rp_q == PW'(CAPACITY - 1)) ? '0 : rp_q + PW'(1);
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // scaled samples from the read pipeline; never coincide with the above
    if (mul_tag.vld) begin
      res_vld_d        = 1'b1;
      res_d.out_sample = mul_sample;
      res_d.out_valid  = 1'b1;
      res_d.last       = mul_tag.last;
      res_d.push_ok    = 1'b0;
      res_d.free_space = fs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      rem_q     <= '0;
      acc_q     <= 1'b0;
      gain_q    <= GainReset;
      cnt_q     <= '0;
      rd_tag_q  <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      rem_q     <= rem_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      rd_tag_q  <= rd_tag_d;
      res_vld_q <= res_vld_d;
      if (gain_we_i) begin
        gain_q <= gain_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fs_q  <= fs_d;
    res_q <= res_d;
  end

  afg_ram #(
    .Width (SampleW),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (in_i.sample),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  afg_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rd_tag_q),
    .sample_i ($signed(ram_rdata)),
    .gain_i   (gain_q),
    .tag_o    (mul_tag),
    .sample_o (mul_sample)
  );

  assign busy           = (state_q == ST_READ) || rd_tag_q.vld || mul_tag.vld;
  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

  // a read is only issued while something is stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> used_w != '0)
    else $error("read issued on an empty fifo");

  // a write never fills the slot kept empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> used_w != CW'(CAPACITY - 1))
    else $error("write into a full fifo");

  // the write pointer stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, wp_q} < (PW + 1)'(CAPACITY))
    else $error("write pointer out of range");

  // the last read result is on the output when busy drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && res_q.out_valid && res_q.last)
    else $error("busy dropped before the last read transfer");

endmodule
